// ===== rtl/core/ebcs_pkg.sv =====
// package for the eight-bit cpu bus sequencer: phases, modes, kinds, decoder
// no dependencies
package ebcs_pkg;

	localparam int AddrWidth = 16;
	localparam int DataWidth = 8;
	localparam logic [15:0] StartAddressReset = 16'h0000;
	localparam logic [15:0] StackPage = 16'h0100;
	localparam logic [15:0] IrqVector = 16'hFFFE;

	localparam logic [7:0] FlC = 8'h01;
	localparam logic [7:0] FlZ = 8'h02;
	localparam logic [7:0] FlI = 8'h04;
	localparam logic [7:0] FlD = 8'h08;
	localparam logic [7:0] FlBU = 8'h30;
	localparam logic [7:0] FlV = 8'h40;
	localparam logic [7:0] FlN = 8'h80;
	localparam logic [7:0] PullMask = 8'hCF;

	// bus phase sequencer states, one-hot
	typedef enum logic [14:0] {
		PH_RESET = 15'h0001,
		PH_OPCODE = 15'h0002,
		PH_LO = 15'h0004,
		PH_HI = 15'h0008,
		PH_PTR_LO = 15'h0010,
		PH_PTR_HI = 15'h0020,
		PH_DATA = 15'h0040,
		PH_WRITTEN = 15'h0080,
		PH_PULL = 15'h0100,
		PH_STK_LO = 15'h0200,
		PH_STK_HI = 15'h0400,
		PH_RTI_P = 15'h0800,
		PH_PUSH_LO = 15'h1000,
		PH_BRK_P = 15'h2000,
		PH_VEC = 15'h4000
	} phase_t;

	typedef enum logic [3:0] {
		M_IMP, M_IMM, M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABX, M_ABY, M_INX, M_INY, M_REL, M_IND
	} mode_t;

	typedef enum logic [5:0] {
		K_NOP, K_ORA, K_AND, K_EOR, K_ADC, K_STA, K_LDA, K_CMP, K_SBC,
		K_ASL, K_ROL, K_LSR, K_ROR, K_STX, K_LDX, K_DEC, K_INC,
		K_LDY, K_STY, K_CPX, K_CPY, K_BIT, K_BRANCH, K_JMP, K_JSR,
		K_RTS, K_RTI, K_BRK, K_PHA, K_PHP, K_PLA, K_PLP, K_IMPL
	} kind_t;

	typedef struct packed {
		mode_t mode;
		kind_t kind;
	} decode_t;

	// one bus access as it leaves the core
	typedef struct packed {
		logic [15:0] addr;
		logic [7:0] data;
		logic wr;
		logic fetch;
	} bus_t;

	function automatic mode_t alu_mode(input logic [2:0] bbb);
		case (bbb)
			3'd0: alu_mode = M_INX;
			3'd1: alu_mode = M_ZP;
			3'd2: alu_mode = M_IMM;
			3'd3: alu_mode = M_ABS;
			3'd4: alu_mode = M_INY;
			3'd5: alu_mode = M_ZPX;
			3'd6: alu_mode = M_ABY;
			default: alu_mode = M_ABX;
		endcase
	endfunction

	function automatic kind_t kind_add(input kind_t base, input logic [2:0] off);
		kind_add = kind_t'(6'(base) + {3'd0, off});
	endfunction

	// opcode decoder, unlisted codes fall out as implied nops
	function automatic decode_t decode(input logic [7:0] code);
		logic [2:0] aaa;
		logic [2:0] bbb;
		decode_t d;
		aaa = code[7:5];
		bbb = code[4:2];
		d.mode = M_IMP;
		d.kind = K_NOP;
		unique case (code[1:0])
			2'd1: begin
				if (code != 8'h89) begin
					d.mode = alu_mode(bbb);
					d.kind = kind_add(K_ORA, aaa);
				end
			end
			2'd2: begin
				case (bbb)
					3'd0: if (code == 8'hA2) begin
						d.mode = M_IMM;
						d.kind = K_LDX;
					end
					3'd1: begin
						d.mode = M_ZP;
						d.kind = kind_add(K_ASL, aaa);
					end
					3'd2: d.kind = aaa[2] ? K_IMPL : kind_add(K_ASL, aaa);
					3'd3: begin
						d.mode = M_ABS;
						d.kind = kind_add(K_ASL, aaa);
					end
					3'd5: begin
						d.mode = (aaa == 3'd4 || aaa == 3'd5) ? M_ZPY : M_ZPX;
						d.kind = kind_add(K_ASL, aaa);
					end
					3'd6: d.kind = K_IMPL;
					3'd7: if (code != 8'h9E) begin
						d.mode = (aaa == 3'd5) ? M_ABY : M_ABX;
						d.kind = kind_add(K_ASL, aaa);
					end
					default: ;
				endcase
			end
			2'd0: begin
				if (code[4:0] == 5'h10) begin
					d.mode = M_REL;
					d.kind = K_BRANCH;
				end else begin
					case (code)
						8'h00: d.kind = K_BRK;
						8'h20: begin d.mode = M_ABS; d.kind = K_JSR; end
						8'h40: d.kind = K_RTI;
						8'h60: d.kind = K_RTS;
						8'h08: d.kind = K_PHP;
						8'h28: d.kind = K_PLP;
						8'h48: d.kind = K_PHA;
						8'h68: d.kind = K_PLA;
						8'h24: begin d.mode = M_ZP; d.kind = K_BIT; end
						8'h2C: begin d.mode = M_ABS; d.kind = K_BIT; end
						8'h4C: begin d.mode = M_ABS; d.kind = K_JMP; end
						8'h6C: begin d.mode = M_IND; d.kind = K_JMP; end
						8'h84: begin d.mode = M_ZP; d.kind = K_STY; end
						8'h8C: begin d.mode = M_ABS; d.kind = K_STY; end
						8'h94: begin d.mode = M_ZPX; d.kind = K_STY; end
						8'hA0: begin d.mode = M_IMM; d.kind = K_LDY; end
						8'hA4: begin d.mode = M_ZP; d.kind = K_LDY; end
						8'hAC: begin d.mode = M_ABS; d.kind = K_LDY; end
						8'hB4: begin d.mode = M_ZPX; d.kind = K_LDY; end
						8'hBC: begin d.mode = M_ABX; d.kind = K_LDY; end
						8'hC0: begin d.mode = M_IMM; d.kind = K_CPY; end
						8'hC4: begin d.mode = M_ZP; d.kind = K_CPY; end
						8'hCC: begin d.mode = M_ABS; d.kind = K_CPY; end
						8'hE0: begin d.mode = M_IMM; d.kind = K_CPX; end
						8'hE4: begin d.mode = M_ZP; d.kind = K_CPX; end
						8'hEC: begin d.mode = M_ABS; d.kind = K_CPX; end
						default: if (bbb == 3'd2 || bbb == 3'd6) d.kind = K_IMPL;
					endcase
				end
			end
			default: ;
		endcase
		return d;
	endfunction

endpackage

// ===== rtl/core/ebcs_alu.sv =====
// eight-bit alu: logic ops, add with carry, compare, bit test, shifts and inc/dec
// depends on ebcs_pkg
module ebcs_alu import ebcs_pkg::*; (
	input kind_t kind,
	input logic [7:0] a,
	input logic [7:0] x,
	input logic [7:0] y,
	input logic [7:0] datum,
	input logic [7:0] flags_in,
	output logic [7:0] result,
	output logic [7:0] flags_out
);

	logic [8:0] sum;
	logic [7:0] addend;
	logic [7:0] cmp_reg;
	logic [8:0] diff;

	// shared adder for adc and sbc, subtractor for compares
	always_comb begin
		addend = (kind == K_SBC) ? ~datum : datum;
		sum = {1'b0, a} + {1'b0, addend} + {8'd0, flags_in[0]};
		case (kind)
			K_CPX: cmp_reg = x;
			K_CPY: cmp_reg = y;
			default: cmp_reg = a;
		endcase
		diff = {1'b0, cmp_reg} - {1'b0, datum};
	end

	// result and flag selection
	always_comb begin
		result = datum;
		flags_out = flags_in;
		case (kind)
			K_ORA: result = a | datum;
			K_AND: result = a & datum;
			K_EOR: result = a ^ datum;
			K_ADC, K_SBC: begin
				result = sum[7:0];
				flags_out[0] = sum[8];
				flags_out[6] = ((a ^ sum[7:0]) & (addend ^ sum[7:0]) & FlN) != 8'd0;
			end
			K_CMP, K_CPX, K_CPY: begin
				result = diff[7:0];
				flags_out[0] = ~diff[8];
			end
			K_ASL: begin
				result = {datum[6:0], 1'b0};
				flags_out[0] = datum[7];
			end
			K_ROL: begin
				result = {datum[6:0], flags_in[0]};
				flags_out[0] = datum[7];
			end
			K_LSR: begin
				result = {1'b0, datum[7:1]};
				flags_out[0] = datum[0];
			end
			K_ROR: begin
				result = {flags_in[0], datum[7:1]};
				flags_out[0] = datum[0];
			end
			K_INC: result = datum + 8'd1;
			K_DEC: result = datum - 8'd1;
			default: result = datum;
		endcase
		if (kind == K_BIT) begin
			flags_out[7] = datum[7];
			flags_out[6] = datum[6];
			flags_out[1] = (a & datum) == 8'd0;
		end else begin
			flags_out[7] = result[7];
			flags_out[1] = result == 8'd0;
		end
	end

endmodule

// ===== rtl/core/eight_bit_cpu_bus_sequencer.sv =====
// top level of the eight-bit cpu bus sequencer: register file, phase sequencer, output stage
// depends on ebcs_pkg and ebcs_alu
// One item in is the byte read by the previous bus access; one item out is the next bus
// access (address, write data, write flag, opcode-fetch mark). The decode, alu and address logic sit
// between the cpu state registers and one output register, so a new item is taken every cycle
// while the output register is free or being drained. The first item after reset loads the pc
// from start_address and fetches the first opcode; its read_byte is ignored. Decimal mode and
// interrupts are not implemented.
module eight_bit_cpu_bus_sequencer import ebcs_pkg::*; #(
	parameter logic [15:0] START_RESET = StartAddressReset
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [15:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] read_byte,
	output logic out_valid,
	input logic out_stall,
	output logic [15:0] bus_address,
	output logic [7:0] write_byte,
	output logic is_write,
	output logic opcode_fetch
);

	logic [15:0] start_q;
	logic [7:0] a_q, x_q, y_q, sp_q, p_q, op_q, lat_q;
	logic [15:0] pc_q, ea_q;
	phase_t ph_q;
	bus_t out_q;
	logic out_valid_q;

	logic [7:0] a_d, x_d, y_d, sp_d, p_d, op_d, lat_d;
	logic [15:0] pc_d, ea_d;
	phase_t ph_d;
	bus_t bus;
	decode_t dec;
	logic accept;
	logic [7:0] alu_in, alu_res, alu_flags;
	kind_t alu_kind;

	assign cfg_ready = 1'b1;
	assign in_stall = out_valid_q & out_stall;
	assign accept = in_valid & ~in_stall;

	ebcs_alu u_alu (
		.kind(alu_kind), .a(a_q), .x(x_q), .y(y_q), .datum(alu_in),
		.flags_in(p_q), .result(alu_res), .flags_out(alu_flags)
	);

	// sequencer next state
	always_comb begin
		logic [7:0] v;
		logic [15:0] w;
		logic [15:0] pcinc;
		logic br_set;
		a_d = a_q; x_d = x_q; y_d = y_q; sp_d = sp_q; p_d = p_q;
		op_d = op_q; lat_d = lat_q; pc_d = pc_q; ea_d = ea_q; ph_d = ph_q;
		bus = '0;
		v = 8'd0;
		w = 16'd0;
		br_set = 1'b0;
		pcinc = pc_q + 16'd1;
		dec = decode((ph_q == PH_OPCODE) ? read_byte : op_q);
		alu_kind = dec.kind;
		alu_in = read_byte;
		unique case (ph_q)
			PH_OPCODE: begin
				op_d = read_byte;
				if (dec.mode == M_IMP) begin
					case (dec.kind)
						K_PHA, K_PHP: begin
							bus = '{StackPage | {8'd0, sp_q},
								(dec.kind == K_PHA) ? a_q : (p_q | FlBU), 1'b1, 1'b0};
							sp_d = sp_q - 8'd1;
							ph_d = PH_WRITTEN;
						end
						K_PLA, K_PLP, K_RTS, K_RTI: begin
							sp_d = sp_q + 8'd1;
							bus = '{StackPage | {8'd0, sp_d}, 8'd0, 1'b0, 1'b0};
							ph_d = (dec.kind == K_RTS) ? PH_STK_LO :
								(dec.kind == K_RTI) ? PH_RTI_P : PH_PULL;
						end
						K_BRK: begin
							pc_d = pc_q + 16'd1;
							bus = '{StackPage | {8'd0, sp_q}, pc_d[15:8], 1'b1, 1'b0};
							sp_d = sp_q - 8'd1;
							ph_d = PH_PUSH_LO;
						end
						K_ASL, K_ROL, K_LSR, K_ROR: begin
							alu_in = a_q;
							a_d = alu_res;
							p_d = alu_flags;
							bus = '{pc_q, 8'd0, 1'b0, 1'b1};
							pc_d = pcinc;
							ph_d = PH_OPCODE;
						end
						default: begin
							// implied register and flag ops
							v = 8'd0;
							case (read_byte)
								8'h18: p_d = p_q & ~FlC;
								8'h38: p_d = p_q | FlC;
								8'h58: p_d = p_q & ~FlI;
								8'h78: p_d = p_q | FlI;
								8'hB8: p_d = p_q & ~FlV;
								8'hD8: p_d = p_q & ~FlD;
								8'hF8: p_d = p_q | FlD;
								8'h9A: sp_d = x_q;
								8'hAA: begin v = a_q; x_d = v; end
								8'hA8: begin v = a_q; y_d = v; end
								8'h8A: begin v = x_q; a_d = v; end
								8'h98: begin v = y_q; a_d = v; end
								8'hBA: begin v = sp_q; x_d = v; end
								8'hE8: begin v = x_q + 8'd1; x_d = v; end
								8'hC8: begin v = y_q + 8'd1; y_d = v; end
								8'hCA: begin v = x_q - 8'd1; x_d = v; end
								8'h88: begin v = y_q - 8'd1; y_d = v; end
								default: ;
							endcase
							case (read_byte)
								8'hAA, 8'hA8, 8'h8A, 8'h98, 8'hBA, 8'hE8, 8'hC8, 8'hCA, 8'h88:
									p_d = {v[7], p_q[6:2], v == 8'd0, p_q[0]};
								default: ;
							endcase
							bus = '{pc_q, 8'd0, 1'b0, 1'b1};
							pc_d = pcinc;
							ph_d = PH_OPCODE;
						end
					endcase
				end else begin
					ea_d = pc_q;
					bus = '{pc_q, 8'd0, 1'b0, 1'b0};
					pc_d = pcinc;
					ph_d = (dec.mode == M_IMM) ? PH_DATA : PH_LO;
				end
			end
			PH_LO: begin
				lat_d = read_byte;
				case (dec.mode)
					M_REL: begin
						case (op_q[7:6])
							2'd0: br_set = p_q[7];
							2'd1: br_set = p_q[6];
							2'd2: br_set = p_q[0];
							default: br_set = p_q[1];
						endcase
						w = pc_q;
						if (br_set == op_q[5])
							w = pc_q + {{8{read_byte[7]}}, read_byte};
						bus = '{w, 8'd0, 1'b0, 1'b1};
						pc_d = w + 16'd1;
						ph_d = PH_OPCODE;
					end
					M_ZP, M_ZPX, M_ZPY: begin
						v = read_byte + ((dec.mode == M_ZPX) ? x_q :
							(dec.mode == M_ZPY) ? y_q : 8'd0);
						ea_d = {8'd0, v};
					end
					M_INX: begin
						lat_d = read_byte + x_q;
						bus = '{{8'd0, lat_d}, 8'd0, 1'b0, 1'b0};
						ph_d = PH_PTR_LO;
					end
					M_INY: begin
						bus = '{{8'd0, read_byte}, 8'd0, 1'b0, 1'b0};
						ph_d = PH_PTR_LO;
					end
					default: begin
						bus = '{pc_q, 8'd0, 1'b0, 1'b0};
						pc_d = pcinc;
						ph_d = PH_HI;
					end
				endcase
			end
			PH_HI: begin
				w = {read_byte, lat_q};
				if (dec.kind == K_JMP && dec.mode == M_ABS) begin
					bus = '{w, 8'd0, 1'b0, 1'b1};
					pc_d = w + 16'd1;
					ph_d = PH_OPCODE;
				end else if (dec.kind == K_JSR) begin
					ea_d = w;
					pc_d = pc_q - 16'd1;
					bus = '{StackPage | {8'd0, sp_q}, pc_d[15:8], 1'b1, 1'b0};
					sp_d = sp_q - 8'd1;
					ph_d = PH_PUSH_LO;
				end else if (dec.mode == M_IND) begin
					ea_d = w;
					bus = '{w, 8'd0, 1'b0, 1'b0};
					ph_d = PH_PTR_LO;
				end else begin
					ea_d = w + ((dec.mode == M_ABX) ? {8'd0, x_q} :
						(dec.mode == M_ABY) ? {8'd0, y_q} : 16'd0);
				end
			end
			PH_PTR_LO: begin
				if (dec.mode == M_IND || dec.kind == K_BRK)
					w = {ea_q[15:8], ea_q[7:0] + 8'd1};
				else
					w = {8'd0, lat_q + 8'd1};
				ea_d = {8'd0, read_byte};
				bus = '{w, 8'd0, 1'b0, 1'b0};
				ph_d = PH_PTR_HI;
			end
			PH_PTR_HI: begin
				w = {read_byte, ea_q[7:0]};
				if (dec.mode == M_IND || dec.kind == K_BRK) begin
					bus = '{w, 8'd0, 1'b0, 1'b1};
					pc_d = w + 16'd1;
					ph_d = PH_OPCODE;
				end else begin
					ea_d = w + ((dec.mode == M_INY) ? {8'd0, y_q} : 16'd0);
				end
			end
			PH_DATA: begin
				case (dec.kind)
					K_ASL, K_ROL, K_LSR, K_ROR, K_INC, K_DEC: begin
						lat_d = alu_res;
						p_d = alu_flags;
						bus = '{ea_q, alu_res, 1'b1, 1'b0};
						ph_d = PH_WRITTEN;
					end
					default: begin
						case (dec.kind)
							K_ORA, K_AND, K_EOR, K_ADC, K_SBC, K_LDA: begin
								a_d = alu_res; p_d = alu_flags;
							end
							K_LDX: begin x_d = alu_res; p_d = alu_flags; end
							K_LDY: begin y_d = alu_res; p_d = alu_flags; end
							K_CMP, K_CPX, K_CPY, K_BIT: p_d = alu_flags;
							default: ;
						endcase
						bus = '{pc_q, 8'd0, 1'b0, 1'b1};
						pc_d = pcinc;
						ph_d = PH_OPCODE;
					end
				endcase
			end
			PH_WRITTEN: begin
				w = (dec.kind == K_JSR) ? ea_q : pc_q;
				bus = '{w, 8'd0, 1'b0, 1'b1};
				pc_d = w + 16'd1;
				ph_d = PH_OPCODE;
			end
			PH_PULL: begin
				if (dec.kind == K_PLA) begin
					a_d = read_byte;
					p_d = {read_byte[7], p_q[6:2], read_byte == 8'd0, p_q[0]};
				end else begin
					p_d = read_byte & PullMask;
				end
				bus = '{pc_q, 8'd0, 1'b0, 1'b1};
				pc_d = pcinc;
				ph_d = PH_OPCODE;
			end
			PH_RTI_P, PH_STK_LO: begin
				if (ph_q == PH_RTI_P) p_d = read_byte & PullMask;
				else lat_d = read_byte;
				sp_d = sp_q + 8'd1;
				bus = '{StackPage | {8'd0, sp_d}, 8'd0, 1'b0, 1'b0};
				ph_d = (ph_q == PH_RTI_P) ? PH_STK_LO : PH_STK_HI;
			end
			PH_STK_HI: begin
				w = {read_byte, lat_q} + ((dec.kind == K_RTS) ? 16'd1 : 16'd0);
				bus = '{w, 8'd0, 1'b0, 1'b1};
				pc_d = w + 16'd1;
				ph_d = PH_OPCODE;
			end
			PH_PUSH_LO: begin
				bus = '{StackPage | {8'd0, sp_q}, pc_q[7:0], 1'b1, 1'b0};
				sp_d = sp_q - 8'd1;
				ph_d = (dec.kind == K_BRK) ? PH_BRK_P : PH_WRITTEN;
			end
			PH_BRK_P: begin
				bus = '{StackPage | {8'd0, sp_q}, p_q | FlBU, 1'b1, 1'b0};
				sp_d = sp_q - 8'd1;
				p_d = p_q | FlI;
				ph_d = PH_VEC;
			end
			PH_VEC: begin
				ea_d = IrqVector;
				bus = '{IrqVector, 8'd0, 1'b0, 1'b0};
				ph_d = PH_PTR_LO;
			end
			default: begin
				bus = '{start_q, 8'd0, 1'b0, 1'b1};
				pc_d = start_q + 16'd1;
				ph_d = PH_OPCODE;
			end
		endcase
		// effective address is ready: store or read the operand
		if ((ph_q == PH_LO && (dec.mode == M_ZP || dec.mode == M_ZPX || dec.mode == M_ZPY)) ||
			(ph_q == PH_HI && !(dec.kind == K_JMP) && dec.kind != K_JSR &&
				dec.mode != M_IND) ||
			(ph_q == PH_PTR_HI && dec.mode != M_IND && dec.kind != K_BRK)) begin
			case (dec.kind)
				K_STA: begin bus = '{ea_d, a_q, 1'b1, 1'b0}; ph_d = PH_WRITTEN; end
				K_STX: begin bus = '{ea_d, x_q, 1'b1, 1'b0}; ph_d = PH_WRITTEN; end
				K_STY: begin bus = '{ea_d, y_q, 1'b1, 1'b0}; ph_d = PH_WRITTEN; end
				default: begin bus = '{ea_d, 8'd0, 1'b0, 1'b0}; ph_d = PH_DATA; end
			endcase
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= START_RESET;
		end else if (cfg_valid && cfg_ready) begin
			start_q <= cfg_data;
		end
	end

	// cpu state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= '0; x_q <= '0; y_q <= '0; sp_q <= 8'hFF; p_q <= '0;
			op_q <= '0; lat_q <= '0; pc_q <= '0; ea_q <= '0; ph_q <= PH_RESET;
		end else if (accept) begin
			a_q <= a_d; x_q <= x_d; y_q <= y_d; sp_q <= sp_d; p_q <= p_d;
			op_q <= op_d; lat_q <= lat_d; pc_q <= pc_d; ea_q <= ea_d; ph_q <= ph_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) out_q <= bus;
	end

	assign out_valid = out_valid_q;
	assign bus_address = out_q.addr;
	assign write_byte = out_q.data;
	assign is_write = out_q.wr;
	assign opcode_fetch = out_q.fetch;

	// a write never fetches an opcode
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(is_write && opcode_fetch)) else $error("write marked as fetch");
	// the first item after reset fetches an opcode
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && ph_q == PH_RESET |=> opcode_fetch) else $error("reset fetch missing");
	// stall holds the output item
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_q)) else $error("output lost");
	// a write payload always lands in the stack page for the PH_PUSH_LO phase
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && ph_q == PH_PUSH_LO |=> is_write && bus_address[15:8] == 8'h01)
		else $error("push outside stack page");

endmodule

// ===== tb/eight_bit_cpu_bus_sequencer_tb.sv =====
// testbench for the eight-bit cpu bus sequencer: directed opcodes, then random programs
// from a byte-wide memory image, checked against an item-by-item cpu predictor
// depends on ebcs_pkg and the eight_bit_cpu_bus_sequencer rtl
module eight_bit_cpu_bus_sequencer_tb;
	import ebcs_pkg::*;

	localparam int CycleLimit = 600000;
	localparam int DrainCycles = 8;

	// opcodes named where the predictor or the directed items need them
	localparam logic [7:0] OP_BRK = 8'h00, OP_PHP = 8'h08, OP_PLP = 8'h28, OP_ROR_A = 8'h6A;
	localparam logic [7:0] OP_LDA_IMM = 8'hA9, OP_ADC_IMM = 8'h69, OP_SBC_IMM = 8'hE9;
	localparam logic [7:0] OP_JMP_IND = 8'h6C, OP_UNLISTED = 8'h02;
	localparam logic [7:0] OP_CLC = 8'h18, OP_SEC = 8'h38, OP_CLI = 8'h58, OP_SEI = 8'h78;
	localparam logic [7:0] OP_CLV = 8'hB8, OP_CLD = 8'hD8, OP_SED = 8'hF8;
	localparam logic [7:0] OP_TAX = 8'hAA, OP_TAY = 8'hA8, OP_TXA = 8'h8A, OP_TYA = 8'h98;
	localparam logic [7:0] OP_TSX = 8'hBA, OP_TXS = 8'h9A, OP_INX = 8'hE8, OP_INY = 8'hC8;
	localparam logic [7:0] OP_DEX = 8'hCA, OP_DEY = 8'h88;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [15:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [7:0] read_byte;
	logic out_valid;
	logic out_stall;
	logic [15:0] bus_address;
	logic [7:0] write_byte;
	logic is_write;
	logic opcode_fetch;

	eight_bit_cpu_bus_sequencer u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .read_byte(read_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.bus_address(bus_address), .write_byte(write_byte),
		.is_write(is_write), .opcode_fetch(opcode_fetch)
	);

	// cpu state as the predictor sees it
	logic [7:0] cpu_a, cpu_x, cpu_y, cpu_sp, cpu_p, cpu_op, cpu_latch;
	logic [15:0] cpu_pc, cpu_ea, start_pc;
	phase_t cpu_phase;
	bus_t next_access;

	// memory image behind the bus and the access that the next item answers
	logic [7:0] ram [0:65535];
	bus_t last_access;

	bus_t access_q[$];
	int errors;
	int cycles;
	int send_idle_pct;
	int rx_stall_pct;
	int hold_req;
	int hold_left;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// bus access helpers
	function automatic void bus_rd(input logic [15:0] a, input phase_t n);
		next_access = '{addr: a, data: 8'h00, wr: 1'b0, fetch: 1'b0};
		cpu_phase = n;
	endfunction

	function automatic void bus_wr(input logic [15:0] a, input logic [7:0] d, input phase_t n);
		next_access = '{addr: a, data: d, wr: 1'b1, fetch: 1'b0};
		cpu_phase = n;
	endfunction

	function automatic void fetch_opcode();
		next_access = '{addr: cpu_pc, data: 8'h00, wr: 1'b0, fetch: 1'b1};
		cpu_pc = cpu_pc + 16'd1;
		cpu_phase = PH_OPCODE;
	endfunction

	function automatic void push(input logic [7:0] d, input phase_t n);
		bus_wr(StackPage | {8'h00, cpu_sp}, d, n);
		cpu_sp = cpu_sp - 8'd1;
	endfunction

	function automatic void pull(input phase_t n);
		cpu_sp = cpu_sp + 8'd1;
		bus_rd(StackPage | {8'h00, cpu_sp}, n);
	endfunction

	function automatic void set_nz(input logic [7:0] v);
		cpu_p = (cpu_p & ~(FlN | FlZ)) | (v & FlN) | ((v == 8'h00) ? FlZ : 8'h00);
	endfunction

	// decode from the aaa/bbb/cc fields of the opcode
	function automatic void op_decode(input logic [7:0] c, output mode_t m, output kind_t k);
		logic [2:0] aaa;
		logic [2:0] bbb;
		aaa = c[7:5];
		bbb = c[4:2];
		m = M_IMP;
		k = K_NOP;
		case (c[1:0])
			2'd1: if (!(aaa == 3'd4 && bbb == 3'd2)) begin
				case (bbb)
					3'd0: m = M_INX;
					3'd1: m = M_ZP;
					3'd2: m = M_IMM;
					3'd3: m = M_ABS;
					3'd4: m = M_INY;
					3'd5: m = M_ZPX;
					3'd6: m = M_ABY;
					default: m = M_ABX;
				endcase
				k = kind_t'(int'(K_ORA) + aaa);
			end
			2'd2: begin
				case (bbb)
					3'd0: if (aaa == 3'd5) begin
						m = M_IMM;
						k = K_LDX;
					end
					3'd1: begin
						m = M_ZP;
						k = kind_t'(int'(K_ASL) + aaa);
					end
					3'd2: k = (aaa < 3'd4) ? kind_t'(int'(K_ASL) + aaa) : K_IMPL;
					3'd3: begin
						m = M_ABS;
						k = kind_t'(int'(K_ASL) + aaa);
					end
					3'd5: begin
						m = (aaa == 3'd4 || aaa == 3'd5) ? M_ZPY : M_ZPX;
						k = kind_t'(int'(K_ASL) + aaa);
					end
					3'd6: k = K_IMPL;
					3'd7: if (aaa != 3'd4) begin
						m = (aaa == 3'd5) ? M_ABY : M_ABX;
						k = kind_t'(int'(K_ASL) + aaa);
					end
					default: ;
				endcase
			end
			2'd0: begin
				case (bbb)
					3'd4: begin
						m = M_REL;
						k = K_BRANCH;
					end
					3'd0: case (aaa)
						3'd0: k = K_BRK;
						3'd1: begin m = M_ABS; k = K_JSR; end
						3'd2: k = K_RTI;
						3'd3: k = K_RTS;
						3'd5: begin m = M_IMM; k = K_LDY; end
						3'd6: begin m = M_IMM; k = K_CPY; end
						3'd7: begin m = M_IMM; k = K_CPX; end
						default: ;
					endcase
					3'd2: case (aaa)
						3'd0: k = K_PHP;
						3'd1: k = K_PLP;
						3'd2: k = K_PHA;
						3'd3: k = K_PLA;
						default: k = K_IMPL;
					endcase
					3'd6: k = K_IMPL;
					3'd1, 3'd3: begin
						m = (bbb == 3'd1) ? M_ZP : M_ABS;
						case (aaa)
							3'd1: k = K_BIT;
							3'd2: if (bbb == 3'd3) k = K_JMP;
							3'd3: if (bbb == 3'd3) begin m = M_IND; k = K_JMP; end
							3'd4: k = K_STY;
							3'd5: k = K_LDY;
							3'd6: k = K_CPY;
							3'd7: k = K_CPX;
							default: ;
						endcase
						if (k == K_NOP) m = M_IMP;
					end
					3'd5: if (aaa == 3'd4 || aaa == 3'd5) begin
						m = M_ZPX;
						k = (aaa == 3'd4) ? K_STY : K_LDY;
					end
					3'd7: if (aaa == 3'd5) begin
						m = M_ABX;
						k = K_LDY;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	endfunction

	// binary add with carry, sbc feeds the inverted operand
	function automatic void add_carry(input logic [7:0] v);
		logic [8:0] sum;
		sum = {1'b0, cpu_a} + {1'b0, v} + {8'h00, cpu_p[0]};
		cpu_p = cpu_p & ~(FlC | FlV);
		if (sum[8]) cpu_p = cpu_p | FlC;
		if (((cpu_a ^ sum[7:0]) & (v ^ sum[7:0]) & 8'h80) != 8'h00) cpu_p = cpu_p | FlV;
		cpu_a = sum[7:0];
		set_nz(cpu_a);
	endfunction

	function automatic void compare(input logic [7:0] r, input logic [7:0] d);
		cpu_p = (cpu_p & ~FlC) | ((r >= d) ? FlC : 8'h00);
		set_nz(r - d);
	endfunction

	function automatic void exec_read(input kind_t k, input logic [7:0] d);
		case (k)
			K_ORA: begin cpu_a = cpu_a | d; set_nz(cpu_a); end
			K_AND: begin cpu_a = cpu_a & d; set_nz(cpu_a); end
			K_EOR: begin cpu_a = cpu_a ^ d; set_nz(cpu_a); end
			K_ADC: add_carry(d);
			K_SBC: add_carry(~d);
			K_LDA: begin cpu_a = d; set_nz(d); end
			K_LDX: begin cpu_x = d; set_nz(d); end
			K_LDY: begin cpu_y = d; set_nz(d); end
			K_CMP: compare(cpu_a, d);
			K_CPX: compare(cpu_x, d);
			K_CPY: compare(cpu_y, d);
			K_BIT: cpu_p = (cpu_p & ~(FlN | FlV | FlZ)) | (d & 8'hC0) |
				(((cpu_a & d) == 8'h00) ? FlZ : 8'h00);
			default: ;
		endcase
	endfunction

	// shifts, rotates through carry, inc and dec
	function automatic logic [7:0] alter(input kind_t k, input logic [7:0] d);
		logic [7:0] r;
		logic cin;
		r = d;
		cin = cpu_p[0];
		case (k)
			K_ASL: begin r = {d[6:0], 1'b0}; cpu_p[0] = d[7]; end
			K_ROL: begin r = {d[6:0], cin}; cpu_p[0] = d[7]; end
			K_LSR: begin r = {1'b0, d[7:1]}; cpu_p[0] = d[0]; end
			K_ROR: begin r = {cin, d[7:1]}; cpu_p[0] = d[0]; end
			K_INC: r = d + 8'd1;
			K_DEC: r = d - 8'd1;
			default: ;
		endcase
		set_nz(r);
		return r;
	endfunction

	function automatic void exec_implied(input logic [7:0] c);
		case (c)
			OP_CLC: cpu_p = cpu_p & ~FlC;
			OP_SEC: cpu_p = cpu_p | FlC;
			OP_CLI: cpu_p = cpu_p & ~FlI;
			OP_SEI: cpu_p = cpu_p | FlI;
			OP_CLV: cpu_p = cpu_p & ~FlV;
			OP_CLD: cpu_p = cpu_p & ~FlD;
			OP_SED: cpu_p = cpu_p | FlD;
			OP_TAX: begin cpu_x = cpu_a; set_nz(cpu_x); end
			OP_TAY: begin cpu_y = cpu_a; set_nz(cpu_y); end
			OP_TXA: begin cpu_a = cpu_x; set_nz(cpu_a); end
			OP_TYA: begin cpu_a = cpu_y; set_nz(cpu_a); end
			OP_TSX: begin cpu_x = cpu_sp; set_nz(cpu_x); end
			OP_TXS: cpu_sp = cpu_x;
			OP_INX: begin cpu_x = cpu_x + 8'd1; set_nz(cpu_x); end
			OP_INY: begin cpu_y = cpu_y + 8'd1; set_nz(cpu_y); end
			OP_DEX: begin cpu_x = cpu_x - 8'd1; set_nz(cpu_x); end
			OP_DEY: begin cpu_y = cpu_y - 8'd1; set_nz(cpu_y); end
			default: ;
		endcase
	endfunction

	function automatic void access_target(input kind_t k);
		if (k == K_STA) bus_wr(cpu_ea, cpu_a, PH_WRITTEN);
		else if (k == K_STX) bus_wr(cpu_ea, cpu_x, PH_WRITTEN);
		else if (k == K_STY) bus_wr(cpu_ea, cpu_y, PH_WRITTEN);
		else bus_rd(cpu_ea, PH_DATA);
	endfunction

	function automatic void start_opcode(input mode_t m, input kind_t k);
		if (m == M_IMP) begin
			case (k)
				K_PHA: push(cpu_a, PH_WRITTEN);
				K_PHP: push(cpu_p | FlBU, PH_WRITTEN);
				K_PLA, K_PLP: pull(PH_PULL);
				K_RTS: pull(PH_STK_LO);
				K_RTI: pull(PH_RTI_P);
				K_BRK: begin
					cpu_pc = cpu_pc + 16'd1;
					push(cpu_pc[15:8], PH_PUSH_LO);
				end
				K_ASL, K_ROL, K_LSR, K_ROR: begin
					cpu_a = alter(k, cpu_a);
					fetch_opcode();
				end
				default: begin
					exec_implied(cpu_op);
					fetch_opcode();
				end
			endcase
		end else begin
			cpu_ea = cpu_pc;
			bus_rd(cpu_pc, (m == M_IMM) ? PH_DATA : PH_LO);
			cpu_pc = cpu_pc + 16'd1;
		end
	endfunction

	function automatic void operand_lo(input mode_t m, input kind_t k, input logic [7:0] d);
		logic [7:0] mask;
		cpu_latch = d;
		case (m)
			M_REL: begin
				case (cpu_op[7:6])
					2'd0: mask = FlN;
					2'd1: mask = FlV;
					2'd2: mask = FlC;
					default: mask = FlZ;
				endcase
				if (((cpu_p & mask) != 8'h00) == cpu_op[5])
					cpu_pc = cpu_pc + {{8{d[7]}}, d};
				fetch_opcode();
			end
			M_ZP: begin cpu_ea = {8'h00, d}; access_target(k); end
			M_ZPX: begin cpu_ea = {8'h00, d + cpu_x}; access_target(k); end
			M_ZPY: begin cpu_ea = {8'h00, d + cpu_y}; access_target(k); end
			M_INX: begin
				cpu_latch = d + cpu_x;
				bus_rd({8'h00, cpu_latch}, PH_PTR_LO);
			end
			M_INY: bus_rd({8'h00, d}, PH_PTR_LO);
			default: begin
				bus_rd(cpu_pc, PH_HI);
				cpu_pc = cpu_pc + 16'd1;
			end
		endcase
	endfunction

	function automatic void operand_hi(input mode_t m, input kind_t k, input logic [7:0] d);
		logic [15:0] w;
		w = {d, cpu_latch};
		if (k == K_JMP && m == M_ABS) begin
			cpu_pc = w;
			fetch_opcode();
		end else if (k == K_JSR) begin
			cpu_ea = w;
			cpu_pc = cpu_pc - 16'd1;
			push(cpu_pc[15:8], PH_PUSH_LO);
		end else if (m == M_IND) begin
			cpu_ea = w;
			bus_rd(w, PH_PTR_LO);
		end else begin
			if (m == M_ABX) w = w + {8'h00, cpu_x};
			else if (m == M_ABY) w = w + {8'h00, cpu_y};
			cpu_ea = w;
			access_target(k);
		end
	endfunction

	// one item in, the next bus access out
	function automatic bus_t cpu_step(input logic [7:0] d);
		mode_t m;
		kind_t k;
		logic [15:0] w;
		op_decode(cpu_op, m, k);
		case (cpu_phase)
			PH_OPCODE: begin
				cpu_op = d;
				op_decode(d, m, k);
				start_opcode(m, k);
			end
			PH_LO: operand_lo(m, k, d);
			PH_HI: operand_hi(m, k, d);
			PH_PTR_LO: begin
				// indirect jump keeps the pointer high byte, so the page wraps
				if (m == M_IND || k == K_BRK) w = {cpu_ea[15:8], cpu_ea[7:0] + 8'd1};
				else w = {8'h00, cpu_latch + 8'd1};
				cpu_ea = {8'h00, d};
				bus_rd(w, PH_PTR_HI);
			end
			PH_PTR_HI: begin
				w = {d, cpu_ea[7:0]};
				if (m == M_IND || k == K_BRK) begin
					cpu_pc = w;
					fetch_opcode();
				end else begin
					if (m == M_INY) w = w + {8'h00, cpu_y};
					cpu_ea = w;
					access_target(k);
				end
			end
			PH_DATA: begin
				if (k inside {K_ASL, K_ROL, K_LSR, K_ROR, K_DEC, K_INC}) begin
					cpu_latch = alter(k, d);
					bus_wr(cpu_ea, cpu_latch, PH_WRITTEN);
				end else begin
					exec_read(k, d);
					fetch_opcode();
				end
			end
			PH_WRITTEN: begin
				if (k == K_JSR) cpu_pc = cpu_ea;
				fetch_opcode();
			end
			PH_PULL: begin
				if (k == K_PLA) begin
					cpu_a = d;
					set_nz(d);
				end else begin
					cpu_p = d & PullMask;
				end
				fetch_opcode();
			end
			PH_RTI_P: begin
				cpu_p = d & PullMask;
				pull(PH_STK_LO);
			end
			PH_STK_LO: begin
				cpu_latch = d;
				pull(PH_STK_HI);
			end
			PH_STK_HI: begin
				cpu_pc = {d, cpu_latch};
				if (k == K_RTS) cpu_pc = cpu_pc + 16'd1;
				fetch_opcode();
			end
			PH_PUSH_LO: push(cpu_pc[7:0], (k == K_BRK) ? PH_BRK_P : PH_WRITTEN);
			PH_BRK_P: begin
				push(cpu_p | FlBU, PH_VEC);
				cpu_p = cpu_p | FlI;
			end
			PH_VEC: begin
				cpu_ea = IrqVector;
				bus_rd(IrqVector, PH_PTR_LO);
			end
			default: begin
				cpu_pc = start_pc;
				fetch_opcode();
			end
		endcase
		return next_access;
	endfunction

	// byte the memory image returns for the last access
	function automatic logic [7:0] ram_byte();
		if (last_access.wr) return 8'($urandom);
		return ram[last_access.addr];
	endfunction

	// send one item, then predict the access it causes
	task automatic send_item(input logic [7:0] b);
		bus_t acc;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		read_byte <= b;
		do @(posedge clk); while (in_stall);
		acc = cpu_step(b);
		if (acc.wr) ram[acc.addr] = acc.data;
		last_access = acc;
		access_q.push_back(acc);
	endtask

	task automatic idle_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		idle_input();
		wait (access_q.size() == 0);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_start(input logic [15:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		start_pc = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// reset fetch from the top of memory, then items for each special case
	task automatic test_directed();
		logic [7:0] seq [$];
		seq = '{8'h5A, OP_LDA_IMM, 8'h80, OP_ADC_IMM, 8'h80, OP_SBC_IMM, 8'h00, OP_ROR_A,
			OP_BRK, 8'hFF, 8'h00, 8'hFF, 8'h34, 8'h12,
			OP_JMP_IND, 8'hFF, 8'h10, 8'h00, 8'hFF,
			OP_UNLISTED, OP_TXS, OP_PHP, 8'h00, OP_PLP, 8'hFF};
		write_start(16'hFFFF);
		foreach (seq[i]) send_item(seq[i]);
		wait_drained();
	endtask

	// random programs out of the memory image, with some noise bytes
	task automatic test_programs(input int n, input int in_pct, input int out_pct);
		send_idle_pct = in_pct;
		rx_stall_pct = out_pct;
		repeat (n) send_item(($urandom_range(99) < 8) ? 8'($urandom) : ram_byte());
		wait_drained();
	endtask

	// long output hold-off so the core backs up, then a pause until all drained
	task automatic test_backpressure();
		send_idle_pct = 0;
		rx_stall_pct = 0;
		hold_req = 200;
		repeat (40) send_item(ram_byte());
		wait_drained();
		repeat (20) send_item(ram_byte());
		wait_drained();
	endtask

	// output side: random stalls and the requested hold-off
	always @(negedge clk) begin
		if (hold_req > 0) begin
			hold_left <= hold_req;
			hold_req <= 0;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_stall_pct);
		end
	end

	// compare each accepted access with the oldest prediction
	always @(posedge clk) begin
		bus_t exp_acc;
		if (arst_n && out_valid && !out_stall) begin
			if (access_q.size() == 0) begin
				$display("%0t unexpected access: actual %h %h %b %b", $time,
					bus_address, write_byte, is_write, opcode_fetch);
				errors++;
			end else begin
				exp_acc = access_q.pop_front();
				if (bus_address !== exp_acc.addr) begin
					$display("%0t bus_address expected %h actual %h", $time,
						exp_acc.addr, bus_address);
					errors++;
				end
				if (write_byte !== exp_acc.data) begin
					$display("%0t write_byte expected %h actual %h", $time,
						exp_acc.data, write_byte);
					errors++;
				end
				if (is_write !== exp_acc.wr) begin
					$display("%0t is_write expected %b actual %b", $time,
						exp_acc.wr, is_write);
					errors++;
				end
				if (opcode_fetch !== exp_acc.fetch) begin
					$display("%0t opcode_fetch expected %b actual %b", $time,
						exp_acc.fetch, opcode_fetch);
					errors++;
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 16'h0000;
		in_valid = 1'b0;
		read_byte = 8'h00;
		out_stall = 1'b0;
		errors = 0;
		cycles = 0;
		send_idle_pct = 0;
		rx_stall_pct = 0;
		hold_req = 0;
		hold_left = 0;
		cpu_a = 8'h00;
		cpu_x = 8'h00;
		cpu_y = 8'h00;
		cpu_sp = 8'hFF;
		cpu_p = 8'h00;
		cpu_op = 8'h00;
		cpu_latch = 8'h00;
		cpu_pc = 16'h0000;
		cpu_ea = 16'h0000;
		start_pc = StartAddressReset;
		cpu_phase = PH_RESET;
		last_access = '{addr: 16'h0000, data: 8'h00, wr: 1'b1, fetch: 1'b0};
		for (int i = 0; i < 65536; i++) ram[i] = 8'($urandom);
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_programs(550, 9, 87);
		write_start(16'h0000);
		test_programs(550, 87, 9);
		write_start(16'($urandom));
		test_backpressure();
		test_programs(500, 0, 0);

		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== eight_bit_cpu_bus_sequencer.f =====
rtl/core/ebcs_pkg.sv
rtl/core/ebcs_alu.sv
rtl/core/eight_bit_cpu_bus_sequencer.sv
tb/eight_bit_cpu_bus_sequencer_tb.sv
